// File: sv/odi_pkg.sv
// Shared types, codes and constants for the odometry integrator.
`default_nettype none
package odi_pkg;

	localparam int TRIG_ITERATIONS = 24;

	localparam logic [63:0] SMAX        = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] RATE_MAX    = 64'h0000_0000_8000_0000;
	localparam logic [63:0] RATE_SCALE  = 64'd10000;
	localparam logic [63:0] RAD_TO_TURN = 64'd683565276;
	localparam logic [63:0] ARC_MIN     = 64'd42950;
	localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
	localparam logic [63:0] ARC_ONE     = 64'h0000_0000_4000_0000;

	localparam logic [31:0] LEFT_SCALE_RST  = 32'd220983495;
	localparam logic [31:0] RIGHT_SCALE_RST = 32'd220983495;
	localparam logic [31:0] ITW_RST         = 32'd40720385;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_LEFT_SCALE  = 2'd0;
	localparam cfg_idx_t CFG_RIGHT_SCALE = 2'd1;
	localparam cfg_idx_t CFG_INV_TRACK   = 2'd2;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_FIRST  = 2'd0;
	localparam mode_t MODE_UPDATE = 2'd1;
	localparam mode_t MODE_HOLD   = 2'd2;

	typedef logic [4:0] op_t;
	localparam op_t OP_MUL_PL   = 5'd0;
	localparam op_t OP_MUL_DL   = 5'd1;
	localparam op_t OP_MUL_PR   = 5'd2;
	localparam op_t OP_MUL_DR   = 5'd3;
	localparam op_t OP_MUL_TH   = 5'd4;
	localparam op_t OP_MUL_LIN  = 5'd5;
	localparam op_t OP_DIV_LIN  = 5'd6;
	localparam op_t OP_MUL_TURN = 5'd7;
	localparam op_t OP_DIV_TURN = 5'd8;
	localparam op_t OP_STRAIGHT = 5'd9;
	localparam op_t OP_MUL_ANG  = 5'd10;
	localparam op_t OP_COR_ANG  = 5'd11;
	localparam op_t OP_MUL_DX   = 5'd12;
	localparam op_t OP_DIV_DX   = 5'd13;
	localparam op_t OP_MUL_DY   = 5'd14;
	localparam op_t OP_DIV_DY   = 5'd15;
	localparam op_t OP_COR_YAW  = 5'd16;
	localparam op_t OP_MUL_P1   = 5'd17;
	localparam op_t OP_MUL_P2   = 5'd18;
	localparam op_t OP_MUL_P3   = 5'd19;
	localparam op_t OP_MUL_P4   = 5'd20;
	localparam op_t OP_NONE     = 5'd21;

	typedef struct packed {
		logic  go;
		op_t   op;
		logic  commit;
		mode_t mode;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic started;
		logic dt_pos;
		logic small_turn;
	} sts_t;

	// atan(2^-i) as a full-turn angle, 2^32 per turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: sv/diff_drive_odometry_integrator_unit.sv
// Top level of the differential-drive arc odometry integrator.
// Usage:
//  - Input channel (in_valid/in_ready): one beat per sample (timestamp, left and
//    right wheel rpm). in_ready is high only while the sequencer is idle.
//  - Output channel (out_valid/out_ready): one result beat per sample, held in an
//    output register, so the next sample is taken while a result still waits.
//  - Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0 left
//    scale, 1 right scale, 2 inverse track width. Write only while idle.
//  - Timing: first sample and non-positive dt go from accept through the check
//    state straight to the commit step. A pose update is set by the shared
//    divider (one quotient bit per cycle, two divisions on a straight step and
//    four on an arc; a saturating division skips the quotient bits), plus a
//    64x64 multiplier used 11 to 14 times and a 24-step CORDIC used once or
//    twice.
//  - Samples in flight: one at a time; the next sample is taken only after
//    the previous one has passed the commit step.
//  - Reset: clears pose, yaw, stored sample and started flag; scales return to
//    their defaults; no result beat is pending.
//  - Receiver stall: a finished sample waits in the commit step until the
//    previous result beat is taken; no state changes until then.
`default_nettype none
module diff_drive_odometry_integrator_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [30:0]          sample_time,
	input  wire logic signed [15:0]   left_speed,
	input  wire logic signed [15:0]   right_speed,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [47:0]        pos_x,
	output logic signed [47:0]        pos_y,
	output logic [31:0]               heading,
	output logic signed [31:0]        linear_speed,
	output logic signed [31:0]        turn_rate,
	output logic [1:0]                status,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [31:0]          cfg_data
);
	odi_pkg::cmd_t cmd;
	odi_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	odi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	odi_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_take(in_valid && in_ready),
		.sample_time(sample_time), .left_speed(left_speed), .right_speed(right_speed),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.linear_speed(linear_speed), .turn_rate(turn_rate), .status(status)
	);
endmodule
`default_nettype wire

// File: sv/odi_mul.sv
// 64x64 unsigned multiplier, one 32x32 partial product per cycle.
`default_nettype none
module odi_mul (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [63:0]  a,
	input  wire logic [63:0]  b,
	output logic              done,
	output logic [127:0]      prod
);
	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [6:0]   sh;

	always_comb begin
		ah = cnt_q[0] ? a_q[63:32] : a_q[31:0];
		bh = cnt_q[1] ? b_q[63:32] : b_q[31:0];
		pp = 64'(ah) * 64'(bh);
		sh = (7'(cnt_q[0]) + 7'(cnt_q[1])) << 5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + ({64'd0, pp} << sh);
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

// File: sv/odi_div.sv
// 128 by 64 restoring divider, one quotient bit per cycle, saturating.
`default_nettype none
module odi_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num_hi,
	input  wire logic [63:0] num_lo,
	input  wire logic [63:0] den,
	input  wire logic [63:0] limit,
	output logic             done,
	output logic [63:0]      quot
);
	logic [63:0] r_q, lo_q, q_q, den_q, lim_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] r2, diff;
	logic        ge;
	logic        special;

	assign special = (den == 64'd0) || (num_hi >= den);

	always_comb begin
		r2   = {r_q, lo_q[63]};
		diff = r2 - {1'b0, den_q};
		ge   = r2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !special;
				done_q <= special;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// high half below the divisor: it is loaded as the remainder and the 64 steps shift in the low half
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= num_hi;
			lo_q  <= num_lo;
			den_q <= den;
			lim_q <= limit;
			q_q   <= special ? limit : 64'd0;
		end else if (busy_q) begin
			r_q  <= ge ? diff[63:0] : r2[63:0];
			lo_q <= {lo_q[62:0], 1'b0};
			q_q  <= {q_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quot = (q_q > lim_q) ? lim_q : q_q;
endmodule
`default_nettype wire

// File: sv/odi_cordic.sv
// Iterative rotation CORDIC giving cosine and sine of a full-turn angle in Q1.30.
`default_nettype none
module odi_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [31:0]        angle,
	output logic                    done,
	output logic signed [33:0]      cos_out,
	output logic signed [33:0]      sin_out
);
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] za, zf, at;
	logic               flip_q, fl;
	logic [4:0]         cnt_q;
	logic               busy_q, done_q;

	// fold into +-1/4 turn
	always_comb begin
		za = $signed({{2{angle[31]}}, angle});
		zf = za;
		fl = 1'b0;
		if (za > 34'sh0_4000_0000) begin
			zf = za - 34'sh0_8000_0000;
			fl = 1'b1;
		end else if (za < -34'sh0_4000_0000) begin
			zf = za + 34'sh0_8000_0000;
			fl = 1'b1;
		end
		at = $signed({2'b00, odi_pkg::atan_turn(cnt_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(odi_pkg::TRIG_ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed(odi_pkg::CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= zf;
			flip_q <= fl;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> cnt_q);
				y_q <= y_q + (x_q >>> cnt_q);
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + (y_q >>> cnt_q);
				y_q <= y_q - (x_q >>> cnt_q);
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_out = flip_q ? -x_q : x_q;
	assign sin_out = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

// File: sv/odi_dpath.sv
// Odometry datapath: sample and pose registers, shared multiplier, divider and CORDIC.
`default_nettype none
module odi_dpath (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire odi_pkg::cmd_t          cmd,
	output odi_pkg::sts_t               sts,
	input  wire logic                   in_take,
	input  wire logic [30:0]            sample_time,
	input  wire logic signed [15:0]     left_speed,
	input  wire logic signed [15:0]     right_speed,
	input  wire logic                   cfg_we,
	input  wire odi_pkg::cfg_idx_t      cfg_index,
	input  wire logic [31:0]            cfg_data,
	output logic signed [47:0]          pos_x,
	output logic signed [47:0]          pos_y,
	output logic [31:0]                 heading,
	output logic signed [31:0]          linear_speed,
	output logic signed [31:0]          turn_rate,
	output logic [1:0]                  status
);
	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] sgn(input logic [63:0] m, input logic neg);
		logic [63:0] c;
		c = (m > odi_pkg::SMAX) ? odi_pkg::SMAX : m;
		return neg ? (64'd0 - c) : c;
	endfunction

	function automatic logic [63:0] sat63(input logic [127:0] v);
		return (v[127:63] != '0) ? odi_pkg::SMAX : {1'b0, v[62:0]};
	endfunction

	function automatic logic [31:0] rate_fix(input logic [63:0] q, input logic neg);
		logic [31:0] r;
		if (neg) r = 32'd0 - q[31:0];
		else if (q > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
		else r = q[31:0];
		return r;
	endfunction

	logic [31:0] left_scale_q, right_scale_q, itw_q;
	logic        started_q;
	logic [30:0] cur_t_q, last_t_q;
	logic [15:0] cur_l_q, cur_r_q, last_l_q, last_r_q;
	logic [47:0] x_q, y_q;
	logic [31:0] yaw_q, ang_q, lin_q, turn_q;
	logic [63:0] dl_q, dr_q, th_q, dx_q, dy_q, sx_q, sy_q;
	logic [47:0] ox_q, oy_q;
	logic [31:0] ohd_q, olin_q, oturn_q;
	logic [1:0]  ost_q;
	logic        imm_done_q;

	logic signed [16:0] sum_l, sum_r;
	logic [16:0]        msum_l, msum_r;
	logic [31:0]        dt32;
	logic [30:0]        udt;
	logic [63:0]        sum_lr, len, diff, cx, sx, fdy, smul;
	logic               smul_neg;

	logic         mul_go, div_go, cor_go;
	logic [63:0]  mul_a, mul_b;
	logic         mul_done;
	logic [127:0] prod;
	logic [63:0]  div_hi, div_lo, div_den, div_lim, quot;
	logic         div_done;
	logic [31:0]  cor_ang;
	logic         cor_done;
	logic signed [33:0] cor_c, cor_s;

	always_comb begin
		sum_l  = $signed({cur_l_q[15], cur_l_q}) + $signed({last_l_q[15], last_l_q});
		sum_r  = $signed({cur_r_q[15], cur_r_q}) + $signed({last_r_q[15], last_r_q});
		msum_l = sum_l[16] ? 17'(-sum_l) : 17'(sum_l);
		msum_r = sum_r[16] ? 17'(-sum_r) : 17'(sum_r);
		dt32   = {1'b0, cur_t_q} - {1'b0, last_t_q};
		udt    = dt32[30:0];
		sum_lr = dl_q + dr_q;
		len    = {sum_lr[63], sum_lr[63:1]};
		diff   = dr_q - dl_q;
		cx     = {{30{cor_c[33]}}, cor_c};
		sx     = {{30{cor_s[33]}}, cor_s};
		fdy    = odi_pkg::ARC_ONE - cx;
	end

	assign sts.done       = mul_done | div_done | cor_done | imm_done_q;
	assign sts.started    = started_q;
	assign sts.dt_pos     = !dt32[31] && (dt32 != 32'd0);
	assign sts.small_turn = mag64(th_q) < odi_pkg::ARC_MIN;

	// operand selection per step
	always_comb begin
		mul_go  = 1'b0;
		div_go  = 1'b0;
		cor_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_hi  = {16'd0, prod[127:80]};
		div_lo  = prod[79:16];
		div_den = {33'd0, udt};
		div_lim = odi_pkg::RATE_MAX;
		cor_ang = yaw_q;
		case (cmd.op)
			odi_pkg::OP_MUL_PL: begin
				mul_go = cmd.go; mul_a = {47'd0, msum_l}; mul_b = {32'd0, left_scale_q};
			end
			odi_pkg::OP_MUL_DL, odi_pkg::OP_MUL_DR: begin
				mul_go = cmd.go; mul_a = prod[63:0]; mul_b = {33'd0, udt};
			end
			odi_pkg::OP_MUL_PR: begin
				mul_go = cmd.go; mul_a = {47'd0, msum_r}; mul_b = {32'd0, right_scale_q};
			end
			odi_pkg::OP_MUL_TH: begin
				mul_go = cmd.go; mul_a = mag64(diff); mul_b = {32'd0, itw_q};
			end
			odi_pkg::OP_MUL_LIN: begin
				mul_go = cmd.go; mul_a = mag64(len); mul_b = odi_pkg::RATE_SCALE;
			end
			odi_pkg::OP_MUL_TURN: begin
				mul_go = cmd.go; mul_a = mag64(th_q); mul_b = odi_pkg::RATE_SCALE;
			end
			odi_pkg::OP_DIV_LIN, odi_pkg::OP_DIV_TURN: begin
				div_go = cmd.go;
			end
			odi_pkg::OP_MUL_ANG: begin
				mul_go = cmd.go; mul_a = th_q; mul_b = odi_pkg::RAD_TO_TURN;
			end
			odi_pkg::OP_COR_ANG: begin
				cor_go = cmd.go; cor_ang = ang_q;
			end
			odi_pkg::OP_COR_YAW: begin
				cor_go = cmd.go; cor_ang = yaw_q;
			end
			odi_pkg::OP_MUL_DX: begin
				mul_go = cmd.go; mul_a = mag64(sx); mul_b = mag64(len);
			end
			odi_pkg::OP_MUL_DY: begin
				mul_go = cmd.go; mul_a = mag64(fdy); mul_b = mag64(len);
			end
			odi_pkg::OP_DIV_DX, odi_pkg::OP_DIV_DY: begin
				div_go  = cmd.go;
				div_hi  = {6'd0, prod[127:70]};
				div_lo  = prod[69:6];
				div_den = mag64(th_q);
				div_lim = odi_pkg::SMAX;
			end
			odi_pkg::OP_MUL_P1: begin
				mul_go = cmd.go; mul_a = mag64(cx); mul_b = mag64(dx_q);
			end
			odi_pkg::OP_MUL_P2: begin
				mul_go = cmd.go; mul_a = mag64(sx); mul_b = mag64(dy_q);
			end
			odi_pkg::OP_MUL_P3: begin
				mul_go = cmd.go; mul_a = mag64(sx); mul_b = mag64(dx_q);
			end
			odi_pkg::OP_MUL_P4: begin
				mul_go = cmd.go; mul_a = mag64(cx); mul_b = mag64(dy_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (cmd.op)
			odi_pkg::OP_MUL_P1: smul_neg = cx[63] ^ dx_q[63];
			odi_pkg::OP_MUL_P2: smul_neg = sx[63] ^ dy_q[63];
			odi_pkg::OP_MUL_P3: smul_neg = sx[63] ^ dx_q[63];
			default:            smul_neg = cx[63] ^ dy_q[63];
		endcase
		smul = sgn(sat63({30'd0, prod[127:30]}), smul_neg);
	end

	odi_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(prod)
	);

	odi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num_hi(div_hi), .num_lo(div_lo),
		.den(div_den), .limit(div_lim), .done(div_done), .quot(quot)
	);

	odi_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_go), .angle(cor_ang),
		.done(cor_done), .cos_out(cor_c), .sin_out(cor_s)
	);

	// configuration and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_scale_q  <= odi_pkg::LEFT_SCALE_RST;
			right_scale_q <= odi_pkg::RIGHT_SCALE_RST;
			itw_q         <= odi_pkg::ITW_RST;
			started_q     <= 1'b0;
			last_t_q      <= '0;
			last_l_q      <= '0;
			last_r_q      <= '0;
			x_q           <= '0;
			y_q           <= '0;
			yaw_q         <= '0;
			imm_done_q    <= 1'b0;
		end else begin
			imm_done_q <= cmd.go && (cmd.op == odi_pkg::OP_STRAIGHT);
			if (cfg_we) begin
				case (cfg_index)
					odi_pkg::CFG_LEFT_SCALE:  left_scale_q  <= cfg_data;
					odi_pkg::CFG_RIGHT_SCALE: right_scale_q <= cfg_data;
					odi_pkg::CFG_INV_TRACK:   itw_q         <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				last_t_q <= cur_t_q;
				last_l_q <= cur_l_q;
				last_r_q <= cur_r_q;
				case (cmd.mode)
					odi_pkg::MODE_FIRST: begin
						started_q <= 1'b1;
						x_q       <= '0;
						y_q       <= '0;
						yaw_q     <= '0;
					end
					odi_pkg::MODE_UPDATE: begin
						x_q   <= x_q + sx_q[47:0];
						y_q   <= y_q + sy_q[47:0];
						yaw_q <= yaw_q + ang_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// working registers and result beat
	always_ff @(posedge clk) begin
		if (in_take) begin
			cur_t_q <= sample_time;
			cur_l_q <= left_speed;
			cur_r_q <= right_speed;
		end
		if (sts.done) begin
			case (cmd.op)
				odi_pkg::OP_MUL_DL:   dl_q <= sgn(sat63({17'd0, prod[127:17]}), sum_l[16]);
				odi_pkg::OP_MUL_DR:   dr_q <= sgn(sat63({17'd0, prod[127:17]}), sum_r[16]);
				odi_pkg::OP_MUL_TH:   th_q <= sgn(sat63({24'd0, prod[127:24]}), diff[63]);
				odi_pkg::OP_DIV_LIN:  lin_q <= rate_fix(quot, len[63]);
				odi_pkg::OP_DIV_TURN: turn_q <= rate_fix(quot, th_q[63]);
				odi_pkg::OP_STRAIGHT: begin
					dx_q  <= $unsigned($signed(len) >>> 8);
					dy_q  <= '0;
					ang_q <= '0;
				end
				odi_pkg::OP_MUL_ANG:  ang_q <= prod[63:32];
				odi_pkg::OP_DIV_DX:   dx_q <= sgn(quot, sx[63] ^ len[63] ^ th_q[63]);
				odi_pkg::OP_DIV_DY:   dy_q <= sgn(quot, fdy[63] ^ len[63] ^ th_q[63]);
				odi_pkg::OP_MUL_P1:   sx_q <= smul;
				odi_pkg::OP_MUL_P2:   sx_q <= sx_q - smul;
				odi_pkg::OP_MUL_P3:   sy_q <= smul;
				odi_pkg::OP_MUL_P4:   sy_q <= sy_q + smul;
				default: begin
				end
			endcase
		end
		if (cmd.commit) begin
			ost_q <= cmd.mode;
			case (cmd.mode)
				odi_pkg::MODE_FIRST: begin
					ox_q    <= '0;
					oy_q    <= '0;
					ohd_q   <= '0;
					olin_q  <= '0;
					oturn_q <= '0;
				end
				odi_pkg::MODE_UPDATE: begin
					ox_q    <= x_q + sx_q[47:0];
					oy_q    <= y_q + sy_q[47:0];
					ohd_q   <= yaw_q + ang_q;
					olin_q  <= lin_q;
					oturn_q <= turn_q;
				end
				default: begin
					ox_q    <= x_q;
					oy_q    <= y_q;
					ohd_q   <= yaw_q;
					olin_q  <= '0;
					oturn_q <= '0;
				end
			endcase
		end
	end

	assign pos_x        = $signed(ox_q);
	assign pos_y        = $signed(oy_q);
	assign heading      = ohd_q;
	assign linear_speed = $signed(olin_q);
	assign turn_rate    = $signed(oturn_q);
	assign status       = ost_q;
endmodule
`default_nettype wire

// File: sv/odi_ctrl.sv
// Sequencer for the odometry datapath and the result beat handshake.
`default_nettype none
module odi_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output odi_pkg::cmd_t        cmd,
	input  wire odi_pkg::sts_t   sts
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_ISSUE  = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	function automatic odi_pkg::op_t next_op(input odi_pkg::op_t op, input logic small_turn);
		odi_pkg::op_t n;
		case (op)
			odi_pkg::OP_MUL_PL:   n = odi_pkg::OP_MUL_DL;
			odi_pkg::OP_MUL_DL:   n = odi_pkg::OP_MUL_PR;
			odi_pkg::OP_MUL_PR:   n = odi_pkg::OP_MUL_DR;
			odi_pkg::OP_MUL_DR:   n = odi_pkg::OP_MUL_TH;
			odi_pkg::OP_MUL_TH:   n = odi_pkg::OP_MUL_LIN;
			odi_pkg::OP_MUL_LIN:  n = odi_pkg::OP_DIV_LIN;
			odi_pkg::OP_DIV_LIN:  n = odi_pkg::OP_MUL_TURN;
			odi_pkg::OP_MUL_TURN: n = odi_pkg::OP_DIV_TURN;
			odi_pkg::OP_DIV_TURN: n = small_turn ? odi_pkg::OP_STRAIGHT : odi_pkg::OP_MUL_ANG;
			odi_pkg::OP_STRAIGHT: n = odi_pkg::OP_COR_YAW;
			odi_pkg::OP_MUL_ANG:  n = odi_pkg::OP_COR_ANG;
			odi_pkg::OP_COR_ANG:  n = odi_pkg::OP_MUL_DX;
			odi_pkg::OP_MUL_DX:   n = odi_pkg::OP_DIV_DX;
			odi_pkg::OP_DIV_DX:   n = odi_pkg::OP_MUL_DY;
			odi_pkg::OP_MUL_DY:   n = odi_pkg::OP_DIV_DY;
			odi_pkg::OP_DIV_DY:   n = odi_pkg::OP_COR_YAW;
			odi_pkg::OP_COR_YAW:  n = odi_pkg::OP_MUL_P1;
			odi_pkg::OP_MUL_P1:   n = odi_pkg::OP_MUL_P2;
			odi_pkg::OP_MUL_P2:   n = odi_pkg::OP_MUL_P3;
			odi_pkg::OP_MUL_P3:   n = odi_pkg::OP_MUL_P4;
			default:              n = odi_pkg::OP_NONE;
		endcase
		return n;
	endfunction

	logic [2:0]     state_q;
	odi_pkg::op_t   op_q, nxt;
	odi_pkg::mode_t mode_q;
	logic           out_valid_q;
	logic           slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign nxt       = next_op(op_q, sts.small_turn);

	always_comb begin
		cmd.go     = (state_q == ST_ISSUE);
		cmd.op     = op_q;
		cmd.commit = (state_q == ST_COMMIT) && slot_free;
		cmd.mode   = mode_q;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= odi_pkg::OP_NONE;
			mode_q      <= odi_pkg::MODE_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!sts.started) begin
						mode_q  <= odi_pkg::MODE_FIRST;
						state_q <= ST_COMMIT;
					end else if (!sts.dt_pos) begin
						mode_q  <= odi_pkg::MODE_HOLD;
						state_q <= ST_COMMIT;
					end else begin
						op_q    <= odi_pkg::OP_MUL_PL;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sts.done) begin
						if (nxt == odi_pkg::OP_NONE) begin
							mode_q  <= odi_pkg::MODE_UPDATE;
							state_q <= ST_COMMIT;
						end else begin
							op_q    <= nxt;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_COMMIT: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_go_commit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.go && cmd.commit))
		else $error("step issue and commit in the same cycle");

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit would overwrite an untaken result beat");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result beat raised without a commit");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == ST_WAIT))
		else $error("unit finished outside of a wait");
endmodule
`default_nettype wire
